/* rtl/pdr_pkg.sv */
`timescale 1ns / 1ps

package pdr_pkg;

   localparam int NUM_INPUTS      = 3;
   localparam int NUM_OUTPUTS     = 3;
   localparam int SIGMOID_ENTRIES = 256;

   localparam int NUM_WEIGHTS = NUM_INPUTS * NUM_OUTPUTS;
   localparam int WADDR_W     = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
   localparam int IN_IDX_W    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int OUT_IDX_W   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int SIG_IDX_W   = $clog2(SIGMOID_ENTRIES);
   localparam int SIG_SHIFT   = 27 - SIG_IDX_W;

   // datapath widths
   localparam int SUM_W   = 33 + $clog2(NUM_INPUTS);
   localparam int MA_W    = SUM_W + 1;
   localparam int MB_W    = 18;
   localparam int P_W     = MA_W + MB_W;
   localparam int OUT_W   = 10;
   localparam int E_W     = 17;
   localparam int DELTA_W = 17;
   localparam int ED_W    = 26;
   localparam int SERR_W  = 33 + $clog2(NUM_OUTPUTS);

   // request tdata layout
   localparam int REQ_IDX_LO  = 0;
   localparam int REQ_WVAL_LO = 4;
   localparam int REQ_X_LO    = 20;
   localparam int REQ_T_LO    = REQ_X_LO + 16 * NUM_INPUTS;
   localparam int REQ_BITS    = REQ_T_LO + 16 * NUM_OUTPUTS;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_SERR_LO = OUT_W * NUM_OUTPUTS;
   localparam int RSP_EERR_LO = RSP_SERR_LO + 32;
   localparam int RSP_CONV_BIT = RSP_EERR_LO + 32;
   localparam int RSP_OVF_BIT  = RSP_CONV_BIT + 1;
   localparam int RSP_BITS     = RSP_OVF_BIT + 1;
   localparam int RSP_DATA_W   = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [1:0] CSR_LEARN_RATE   = 2'd0;
   localparam logic [1:0] CSR_SIGMOID_GAIN = 2'd1;
   localparam logic [1:0] CSR_ERROR_GOAL   = 2'd2;
   localparam logic [1:0] CSR_USE_STEP     = 2'd3;

   localparam logic [7:0]  LEARN_RATE_RST   = 8'd128;
   localparam logic [11:0] SIGMOID_GAIN_RST = 12'd256;
   localparam logic [31:0] ERROR_GOAL_RST   = 32'd6554;
   localparam logic        USE_STEP_RST     = 1'b0;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_TRAIN = 1'b1;

   typedef struct packed {
      logic [7:0]  learn_rate;
      logic [11:0] sigmoid_gain;
      logic [31:0] error_goal;
      logic        use_step;
   } cfg_type;

   typedef struct packed {
      logic                              mode;
      logic [3:0]                        weight_index;
      logic [15:0]                       weight_value;
      logic [NUM_INPUTS-1:0][15:0]       x;
      logic [NUM_OUTPUTS-1:0][15:0]      target;
      logic                              epoch_end;
   } req_type;

   typedef struct packed {
      logic [NUM_OUTPUTS-1:0][OUT_W-1:0] outv;
      logic [31:0]                       sample_error;
      logic [31:0]                       epoch_error;
      logic                              epoch_done;
      logic                              converged;
      logic                              weight_overflow;
   } rsp_type;

   // tanh(a/2) table, Q2.30 series for exp(-a/128) squared seven times
   localparam longint unsigned Q30_ONE = 64'd1 << 30;

   typedef logic [8:0] sig_tab_type [SIGMOID_ENTRIES];

   // shift-subtract quotient, only evaluated while building the table
   function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [8:0] sig_entry(int unsigned k);
      longint unsigned a;
      longint unsigned t;
      longint unsigned term;
      longint unsigned y;
      longint unsigned num;
      longint unsigned den;
      longint          acc;
      a    = (longint'(k) << 19) / SIGMOID_ENTRIES;
      t    = a << 7;
      term = Q30_ONE;
      acc  = longint'(Q30_ONE);
      for (int n = 1; n <= 5; n++) begin
         term = udiv64((term * t) >> 30, 64'(n));
         if ((n & 1) != 0) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      y = longint'(acc);
      for (int n = 0; n < 7; n++) begin
         y = (y * y) >> 30;
      end
      num = Q30_ONE - y;
      den = Q30_ONE + y;
      return 9'(udiv64(num * 512 + den, 2 * den));
   endfunction

   function automatic sig_tab_type sig_table_build();
      sig_tab_type tab;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         tab[k] = sig_entry(k);
      end
      return tab;
   endfunction

   localparam sig_tab_type SIG_TABLE = sig_table_build();

endpackage

/* rtl/pdr_core.sv */
`timescale 1ns / 1ps

module pdr_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  pdr_pkg::req_type req,
   input  pdr_pkg::cfg_type cfg,
   input  logic             slot_free,
   output logic             idle,
   output logic             fin,
   output pdr_pkg::rsp_type rsp
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_MAC   = 12'b0000_0000_0010,
      S_SUMW  = 12'b0000_0000_0100,
      S_ACT   = 12'b0000_0000_1000,
      S_LUT   = 12'b0000_0001_0000,
      S_ERR   = 12'b0000_0010_0000,
      S_OSQ   = 12'b0000_0100_0000,
      S_DIFF  = 12'b0000_1000_0000,
      S_DELTA = 12'b0001_0000_0000,
      S_DSTEP = 12'b0010_0000_0000,
      S_UPD   = 12'b0100_0000_0000,
      S_FIN   = 12'b1000_0000_0000
   } state_type;

   localparam logic signed [pdr_pkg::OUT_W-1:0] O_POS = 10'sd256;
   localparam logic signed [pdr_pkg::OUT_W-1:0] O_NEG = -10'sd256;

   function automatic logic signed [pdr_pkg::P_W-1:0] round_shift(
      logic signed [pdr_pkg::P_W-1:0] v, int s);
      logic [pdr_pkg::P_W-1:0] mag;
      logic [pdr_pkg::P_W-1:0] r;
      mag = v[pdr_pkg::P_W-1] ? pdr_pkg::P_W'(-v) : pdr_pkg::P_W'(v);
      r   = (mag + (pdr_pkg::P_W'(1) << (s - 1))) >> s;
      return v[pdr_pkg::P_W-1] ? -signed'(r) : signed'(r);
   endfunction

   state_type state_ff, state_in;
   pdr_pkg::req_type req_ff;

   logic [pdr_pkg::OUT_IDX_W-1:0] i_ff, i_in;
   logic [pdr_pkg::IN_IDX_W-1:0]  j_ff, j_in;

   logic signed [15:0] w_ff [pdr_pkg::NUM_WEIGHTS];
   logic signed [pdr_pkg::OUT_W-1:0] o_ff [pdr_pkg::NUM_OUTPUTS];
   logic signed [pdr_pkg::E_W-1:0]   e_ff [pdr_pkg::NUM_OUTPUTS];

   logic signed [pdr_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic [pdr_pkg::SERR_W-1:0]       serr_ff, serr_in;
   logic signed [pdr_pkg::ED_W-1:0]  ed_ff;
   logic signed [15:0]               wold_ff;
   logic [pdr_pkg::WADDR_W-1:0]      waddr_ff;
   logic signed [pdr_pkg::P_W-1:0]   prod_ff;
   logic acc_pend_ff, sq_pend_ff, wr_pend_ff;
   logic ovf_ff;
   logic [31:0] total_ff, total_in;

   logic i_last, j_last, train;
   logic [pdr_pkg::WADDR_W-1:0]      rd_addr;
   logic signed [15:0]               w_rd, x_cur, tgt_cur;
   logic signed [pdr_pkg::OUT_W-1:0] o_cur, o_sig, o_step;
   logic signed [pdr_pkg::E_W-1:0]   e_cur, e_new;
   logic [pdr_pkg::SUM_W-1:0]        mag;
   logic                             sig_big;
   logic [pdr_pkg::SIG_IDX_W-1:0]    sig_idx;
   logic [8:0]                       sig_mag;
   logic [16:0]                      diff;
   logic signed [pdr_pkg::P_W-1:0]   delta_full, dw_full;
   logic signed [pdr_pkg::DELTA_W-1:0] delta_sig;
   logic signed [pdr_pkg::ED_W-1:0]  ed_cur;
   logic signed [24:0]               nw;
   logic signed [15:0]               nw_sat;
   logic                             nw_ovf;
   logic signed [pdr_pkg::MA_W-1:0]  mul_a;
   logic signed [pdr_pkg::MB_W-1:0]  mul_b;
   logic load_wr;
   logic [31:0] serr_sat, tot_sat;
   logic [32:0] tot_sum;

   assign idle   = (state_ff == S_IDLE);
   assign fin    = (state_ff == S_FIN) && slot_free;
   assign i_last = (i_ff == pdr_pkg::OUT_IDX_W'(pdr_pkg::NUM_OUTPUTS - 1));
   assign j_last = (j_ff == pdr_pkg::IN_IDX_W'(pdr_pkg::NUM_INPUTS - 1));
   assign train  = (req_ff.mode == pdr_pkg::MODE_TRAIN);

   assign rd_addr = pdr_pkg::WADDR_W'(i_ff * pdr_pkg::NUM_INPUTS + j_ff);
   assign w_rd    = w_ff[rd_addr];
   assign x_cur   = signed'(req_ff.x[j_ff]);
   assign tgt_cur = signed'(req_ff.target[i_ff]);
   assign o_cur   = o_ff[i_ff];
   assign e_cur   = e_ff[i_ff];

   // activation
   assign mag     = acc_ff[pdr_pkg::SUM_W-1] ? pdr_pkg::SUM_W'(-acc_ff)
                                             : pdr_pkg::SUM_W'(acc_ff);
   assign sig_big = |prod_ff[pdr_pkg::P_W-1:27];
   assign sig_idx = prod_ff[26:pdr_pkg::SIG_SHIFT];
   assign sig_mag = sig_big ? 9'd256 : pdr_pkg::SIG_TABLE[sig_idx];
   assign o_sig   = acc_ff[pdr_pkg::SUM_W-1] ? -signed'({1'b0, sig_mag})
                                             : signed'({1'b0, sig_mag});
   assign o_step  = acc_ff[pdr_pkg::SUM_W-1] ? O_NEG : O_POS;
   assign e_new   = pdr_pkg::E_W'(tgt_cur) - pdr_pkg::E_W'(o_cur);

   // delta and weight update
   assign diff       = 17'h10000 - prod_ff[16:0];
   assign delta_full = round_shift(prod_ff, 17);
   assign delta_sig  = signed'(delta_full[pdr_pkg::DELTA_W-1:0]);
   assign ed_cur     = (j_ff == '0) ? signed'(prod_ff[pdr_pkg::ED_W-1:0]) : ed_ff;
   assign dw_full    = round_shift(prod_ff, 16);
   assign nw         = signed'({{9{wold_ff[15]}}, wold_ff} + dw_full[24:0]);

   always_comb begin
      nw_ovf = 1'b0;
      nw_sat = nw[15:0];
      if (nw > 25'sd32767) begin
         nw_sat = 16'sh7fff;
         nw_ovf = 1'b1;
      end else if (nw < -25'sd32768) begin
         nw_sat = -16'sh8000;
         nw_ovf = 1'b1;
      end
   end

   assign load_wr = start && (req.mode == pdr_pkg::MODE_LOAD) &&
                    (32'(req.weight_index) < pdr_pkg::NUM_WEIGHTS);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MAC: begin
            mul_a = pdr_pkg::MA_W'(w_rd);
            mul_b = pdr_pkg::MB_W'(x_cur);
         end
         S_ACT: begin
            mul_a = signed'({1'b0, mag});
            mul_b = signed'(pdr_pkg::MB_W'(cfg.sigmoid_gain));
         end
         S_ERR: begin
            mul_a = pdr_pkg::MA_W'(e_new);
            mul_b = pdr_pkg::MB_W'(e_new);
         end
         S_OSQ: begin
            mul_a = pdr_pkg::MA_W'(o_cur);
            mul_b = pdr_pkg::MB_W'(o_cur);
         end
         S_DIFF: begin
            mul_a = pdr_pkg::MA_W'(e_cur);
            mul_b = signed'(pdr_pkg::MB_W'(diff));
         end
         S_DELTA: begin
            mul_a = pdr_pkg::MA_W'(delta_sig);
            mul_b = signed'(pdr_pkg::MB_W'(cfg.learn_rate));
         end
         S_DSTEP: begin
            mul_a = pdr_pkg::MA_W'(e_cur);
            mul_b = signed'(pdr_pkg::MB_W'(cfg.learn_rate));
         end
         S_UPD: begin
            mul_a = pdr_pkg::MA_W'(ed_cur);
            mul_b = pdr_pkg::MB_W'(x_cur);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               i_in     = '0;
               j_in     = '0;
               state_in = (req.mode == pdr_pkg::MODE_TRAIN) ? S_MAC : S_FIN;
            end
         end
         S_MAC: begin
            if (j_last) begin
               j_in     = '0;
               state_in = S_SUMW;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_SUMW: state_in = S_ACT;
         S_ACT: state_in = cfg.use_step ? S_ERR : S_LUT;
         S_LUT: state_in = S_ERR;
         S_ERR: begin
            if (i_last) begin
               i_in     = '0;
               state_in = cfg.use_step ? S_DSTEP : S_OSQ;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_MAC;
            end
         end
         S_OSQ: state_in = S_DIFF;
         S_DIFF: state_in = S_DELTA;
         S_DELTA: state_in = S_UPD;
         S_DSTEP: state_in = S_UPD;
         S_UPD: begin
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  state_in = S_FIN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = cfg.use_step ? S_DSTEP : S_OSQ;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if ((state_ff == S_MAC) && (j_ff == '0)) begin
         acc_in = '0;
      end else if (acc_pend_ff) begin
         acc_in = acc_ff + pdr_pkg::SUM_W'(prod_ff);
      end
   end

   always_comb begin
      serr_in = serr_ff;
      if (start) begin
         serr_in = '0;
      end else if (sq_pend_ff) begin
         serr_in = serr_ff + pdr_pkg::SERR_W'(prod_ff[30:1]);
      end
   end

   // result
   assign serr_sat = (|serr_ff[pdr_pkg::SERR_W-1:32]) ? '1 : serr_ff[31:0];
   assign tot_sum  = {1'b0, total_ff} + {1'b0, serr_sat};
   assign tot_sat  = tot_sum[32] ? '1 : tot_sum[31:0];

   always_comb begin
      rsp = '0;
      if (train) begin
         for (int k = 0; k < pdr_pkg::NUM_OUTPUTS; k++) begin
            rsp.outv[k] = o_ff[k];
         end
         rsp.sample_error    = serr_sat;
         // last weight write lands in the first finish cycle
         rsp.weight_overflow = ovf_ff || (wr_pend_ff && nw_ovf);
         if (req_ff.epoch_end) begin
            rsp.epoch_error = tot_sat;
            rsp.epoch_done  = 1'b1;
            rsp.converged   = (tot_sat <= cfg.error_goal);
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      if (fin && train) begin
         total_in = req_ff.epoch_end ? '0 : tot_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         acc_pend_ff <= 1'b0;
         sq_pend_ff  <= 1'b0;
         wr_pend_ff  <= 1'b0;
         ovf_ff      <= 1'b0;
         total_ff    <= '0;
         for (int k = 0; k < pdr_pkg::NUM_WEIGHTS; k++) begin
            w_ff[k] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         acc_pend_ff <= (state_ff == S_MAC);
         sq_pend_ff  <= (state_ff == S_ERR);
         wr_pend_ff  <= (state_ff == S_UPD);
         total_ff    <= total_in;
         if (start) begin
            ovf_ff <= 1'b0;
         end else if (wr_pend_ff && nw_ovf) begin
            ovf_ff <= 1'b1;
         end
         if (load_wr) begin
            w_ff[pdr_pkg::WADDR_W'(req.weight_index)] <= signed'(req.weight_value);
         end else if (wr_pend_ff) begin
            w_ff[waddr_ff] <= nw_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      acc_ff  <= acc_in;
      serr_ff <= serr_in;
      prod_ff <= mul_a * mul_b;
      if (start) begin
         req_ff <= req;
      end
      if ((state_ff == S_ACT) && cfg.use_step) begin
         o_ff[i_ff] <= o_step;
      end else if (state_ff == S_LUT) begin
         o_ff[i_ff] <= o_sig;
      end
      if (state_ff == S_ERR) begin
         e_ff[i_ff] <= e_new;
      end
      if (state_ff == S_UPD) begin
         wold_ff  <= w_rd;
         waddr_ff <= rd_addr;
         if (j_ff == '0) begin
            ed_ff <= ed_cur;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_conv_needs_done: assert property (@(posedge clock) disable iff (reset)
      fin |-> (!rsp.converged || rsp.epoch_done))
      else $error("converged without epoch close");

   a_epoch_clear: assert property (@(posedge clock) disable iff (reset)
      (fin && train && req_ff.epoch_end) |=> (total_ff == '0))
      else $error("epoch total not cleared");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      (fin && !(train && req_ff.epoch_end)) |=> (total_ff >= $past(total_ff)))
      else $error("epoch total decreased");

   a_fin_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> !(acc_pend_ff || sq_pend_ff))
      else $error("product still pending at finish");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");
`endif

endmodule

/* rtl/perceptron_delta_rule_trainer.sv */
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// req      in         req_tvalid/tready    tdata: weight_index, weight_value, x0..x2,
//                                          target0..target2; tuser: mode; tlast: epoch_end
// rsp      out        rsp_tvalid/tready    tdata: out0..out2, sample_error, epoch_error,
//                                          converged, weight_overflow; tlast: epoch_done
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A weight load goes straight from idle to finish. A training sample runs, per output, the
// products over the inputs, the activation and the error, then per output the delta and
// the weight updates, all through one 36x18 multiplier shared by the sums, the table index,
// the errors, the deltas and the weight updates.
// Reset (synchronous) clears weights, the epoch total and config to defaults.
// A finished result sits in the rsp register; the next request is taken meanwhile.
module perceptron_delta_rule_trainer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // weight_index, weight_value, x0, x1, x2, target0, target1, target2
   input  logic [pdr_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out0, out1, out2, sample_error, epoch_error, converged, weight_overflow
   output logic [pdr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [31:0]                    csr_data
);

   pdr_pkg::cfg_type cfg_ff;
   pdr_pkg::req_type req;
   pdr_pkg::rsp_type res, rsp_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic start, idle, fin, slot_free;

   assign csr_ready  = 1'b1;
   assign req_tready = idle;
   assign start      = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      req              = '0;
      req.mode         = req_tuser;
      req.weight_index = req_tdata[pdr_pkg::REQ_IDX_LO +: 4];
      req.weight_value = req_tdata[pdr_pkg::REQ_WVAL_LO +: 16];
      for (int k = 0; k < pdr_pkg::NUM_INPUTS; k++) begin
         req.x[k] = req_tdata[pdr_pkg::REQ_X_LO + 16 * k +: 16];
      end
      for (int k = 0; k < pdr_pkg::NUM_OUTPUTS; k++) begin
         req.target[k] = req_tdata[pdr_pkg::REQ_T_LO + 16 * k +: 16];
      end
      req.epoch_end = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate   <= pdr_pkg::LEARN_RATE_RST;
         cfg_ff.sigmoid_gain <= pdr_pkg::SIGMOID_GAIN_RST;
         cfg_ff.error_goal   <= pdr_pkg::ERROR_GOAL_RST;
         cfg_ff.use_step     <= pdr_pkg::USE_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pdr_pkg::CSR_LEARN_RATE:   cfg_ff.learn_rate   <= csr_data[7:0];
            pdr_pkg::CSR_SIGMOID_GAIN: cfg_ff.sigmoid_gain <= csr_data[11:0];
            pdr_pkg::CSR_ERROR_GOAL:   cfg_ff.error_goal   <= csr_data;
            pdr_pkg::CSR_USE_STEP:     cfg_ff.use_step     <= csr_data[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   pdr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .cfg       (cfg_ff),
      .slot_free (slot_free),
      .idle      (idle),
      .fin       (fin),
      .rsp       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.epoch_done;

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < pdr_pkg::NUM_OUTPUTS; k++) begin
         rsp_tdata[pdr_pkg::OUT_W * k +: pdr_pkg::OUT_W] = rsp_ff.outv[k];
      end
      rsp_tdata[pdr_pkg::RSP_SERR_LO +: 32]  = rsp_ff.sample_error;
      rsp_tdata[pdr_pkg::RSP_EERR_LO +: 32]  = rsp_ff.epoch_error;
      rsp_tdata[pdr_pkg::RSP_CONV_BIT]       = rsp_ff.converged;
      rsp_tdata[pdr_pkg::RSP_OVF_BIT]        = rsp_ff.weight_overflow;
   end

endmodule
